>>> design/hsv2rgb_pkg.sv
// ============================================================================
// HSV to RGB converter package
// Fixed-point formats, derived widths and reciprocal constants shared by the
// converter pipeline.
// ============================================================================
package hsv2rgb_pkg;

    // Field and fixed-point formats.
    localparam int FIELD_W           = 16;
    localparam int CHANNEL_FRAC_BITS = 15;
    localparam int HUE_FRAC_BITS     = 6;

    // Channel width holds 1.0 exactly.
    localparam int CH_W   = CHANNEL_FRAC_BITS + 1;
    localparam int CH_ONE = 1 << CHANNEL_FRAC_BITS;

    // One full turn and one 60-degree sector in hue units.
    localparam int TURN = 360 << HUE_FRAC_BITS;
    localparam int SECT = 60 << HUE_FRAC_BITS;

    // Whole turns added so that every signed hue becomes non-negative.
    localparam int HUE_OFFSET = TURN * (((1 << (FIELD_W - 1)) + TURN - 1) / TURN);

    // Widths of the hue path.
    localparam int U_W   = $clog2((1 << (FIELD_W - 1)) + HUE_OFFSET);
    localparam int H_W   = $clog2(TURN);
    localparam int REM_W = $clog2(SECT);
    localparam int FX_W  = REM_W + CHANNEL_FRAC_BITS;
    localparam int SEC_W = 3;

    // Floor reciprocals: quotient estimates are low by at most one.
    localparam int RT_W = U_W - $clog2(TURN) + 1;
    localparam int RS_W = H_W - $clog2(SECT) + 1;
    localparam int RF_W = FX_W - $clog2(SECT) + 1;
    localparam longint unsigned RT = (64'd1 << U_W) / TURN;
    localparam longint unsigned RS = (64'd1 << H_W) / SECT;
    localparam longint unsigned RF = (64'd1 << FX_W) / SECT;

    // Pipeline depth.
    localparam int NUM_STAGES = 8;

    // Sector codes, red/green/blue ordering follows the hue wheel.
    localparam logic [SEC_W-1:0] SEC_RED_YELLOW    = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YELLOW_GREEN  = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GREEN_CYAN    = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CYAN_BLUE     = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BLUE_MAGENTA  = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MAGENTA_RED   = 3'd5;

    // Values that travel alongside the hue path.
    typedef struct packed {
        logic [CH_W-1:0]    sat;
        logic [CH_W-1:0]    val;
        logic [CH_W-1:0]    p;
        logic [FIELD_W-1:0] alpha;
        logic               grey;
    } side_t;

endpackage

>>> design/hsv_to_rgb_converter_top.sv
// ============================================================================
// HSV to RGB converter
// Converts a hue/saturation/brightness/alpha word into red/green/blue/alpha.
// ============================================================================
// The converter takes one word per clock cycle while the output is not
// stalled and returns the results in order. The pipeline depth is set by the
// hue path, which reduces the hue to one turn, splits it into sector and
// fraction by two constant-reciprocal divisions with correction, and then
// runs two rounds of products for q and t. A stalled output holds the whole
// pipeline; nothing is dropped.
// ============================================================================
module hsv_to_rgb_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata: hue_angle, sat_level, value_level, alpha_in (from bit 0)
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // m_axis_tdata: red, green, blue, alpha_out (from bit 0)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata
);
    import hsv2rgb_pkg::*;

    localparam logic [CH_W-1:0] ONE_C  = CH_W'(CH_ONE);
    localparam logic [U_W-1:0]  TURN_U = U_W'(TURN);
    localparam logic [H_W-1:0]  SECT_H = H_W'(SECT);
    localparam logic [FX_W-1:0] SECT_F = FX_W'(SECT);

    // Pipeline control: every stage moves when the last one is free or taken.
    logic                  adv;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;

    assign adv           = !valid_reg[NUM_STAGES-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign valid_next    = {valid_reg[NUM_STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: clamp, make hue non-negative, estimate whole turns, form p.
    logic signed [FIELD_W-1:0] hue_in;
    logic [FIELD_W-1:0]        sat_in;
    logic [FIELD_W-1:0]        val_in;
    logic [CH_W-1:0]           sat_c;
    logic [CH_W-1:0]           val_c;
    logic [U_W-1:0]            u_wide;
    logic [U_W+RT_W-1:0]       prod_t;
    logic [2*CH_W-1:0]         prod_p;
    logic [U_W-1:0]            u1_reg,  u1_next;
    logic [RT_W-1:0]           nt1_reg, nt1_next;
    side_t                     side1_reg, side1_next;

    always_comb
    begin
        hue_in = s_axis_tdata[15:0];
        sat_in = s_axis_tdata[31:16];
        val_in = s_axis_tdata[47:32];
        sat_c  = (32'(sat_in) > 32'(CH_ONE)) ? ONE_C : CH_W'(sat_in);
        val_c  = (32'(val_in) > 32'(CH_ONE)) ? ONE_C : CH_W'(val_in);
        u_wide = U_W'(int'(hue_in) + HUE_OFFSET);
        prod_t = (U_W+RT_W)'(u_wide) * (U_W+RT_W)'(RT);
        prod_p = (2*CH_W)'(val_c) * (2*CH_W)'(ONE_C - sat_c);
        u1_next            = u_wide;
        nt1_next           = prod_t[U_W +: RT_W];
        side1_next.sat     = sat_c;
        side1_next.val     = val_c;
        side1_next.p       = prod_p[CHANNEL_FRAC_BITS +: CH_W];
        side1_next.alpha   = s_axis_tdata[63:48];
        side1_next.grey    = (sat_c == '0);
    end

    // Stage 2: remove whole turns, correct the estimate by one turn.
    logic [U_W-1:0] h_wide;
    logic [H_W-1:0] h2_reg, h2_next;
    side_t          side2_reg;

    always_comb
    begin
        h_wide  = u1_reg - U_W'(nt1_reg) * TURN_U;
        h2_next = H_W'((h_wide >= TURN_U) ? h_wide - TURN_U : h_wide);
    end

    // Stage 3: estimate the sector index.
    logic [H_W+RS_W-1:0] prod_s;
    logic [H_W-1:0]      h3_reg;
    logic [RS_W-1:0]     ns3_reg, ns3_next;
    side_t               side3_reg;

    always_comb
    begin
        prod_s   = (H_W+RS_W)'(h2_reg) * (H_W+RS_W)'(RS);
        ns3_next = prod_s[H_W +: RS_W];
    end

    // Stage 4: remainder within the sector, correct the sector by one.
    logic [H_W-1:0]   rem_wide;
    logic [REM_W-1:0] rem4_reg, rem4_next;
    logic [SEC_W-1:0] sec4_reg, sec4_next;
    side_t            side4_reg;

    always_comb
    begin
        rem_wide = h3_reg - H_W'(ns3_reg) * SECT_H;
        if (rem_wide >= SECT_H)
        begin
            rem4_next = REM_W'(rem_wide - SECT_H);
            sec4_next = SEC_W'(ns3_reg) + SEC_W'(1);
        end
        else
        begin
            rem4_next = REM_W'(rem_wide);
            sec4_next = SEC_W'(ns3_reg);
        end
    end

    // Stage 5: estimate the fraction within the sector.
    logic [FX_W-1:0]      x4;
    logic [FX_W+RF_W-1:0] prod_f;
    logic [REM_W-1:0]     rem5_reg;
    logic [RF_W-1:0]      fe5_reg, fe5_next;
    logic [SEC_W-1:0]     sec5_reg;
    side_t                side5_reg;

    always_comb
    begin
        x4       = {rem4_reg, {CHANNEL_FRAC_BITS{1'b0}}};
        prod_f   = (FX_W+RF_W)'(x4) * (FX_W+RF_W)'(RF);
        fe5_next = prod_f[FX_W +: RF_W];
    end

    // Stage 6: correct the fraction by one.
    logic [FX_W-1:0]              x5;
    logic [FX_W-1:0]              d5;
    logic [CHANNEL_FRAC_BITS-1:0] f6_reg, f6_next;
    logic [SEC_W-1:0]             sec6_reg;
    side_t                        side6_reg;

    always_comb
    begin
        x5      = {rem5_reg, {CHANNEL_FRAC_BITS{1'b0}}};
        d5      = x5 - FX_W'(fe5_reg) * SECT_F;
        f6_next = (d5 >= SECT_F) ? CHANNEL_FRAC_BITS'(fe5_reg + RF_W'(1))
                                 : CHANNEL_FRAC_BITS'(fe5_reg);
    end

    // Stage 7: saturation scaled by the fraction and by its complement.
    logic [CH_W+CHANNEL_FRAC_BITS-1:0] prod_q;
    logic [2*CH_W-1:0]                 prod_tm;
    logic [CH_W-1:0]                   mq7_reg, mq7_next;
    logic [CH_W-1:0]                   mt7_reg, mt7_next;
    logic [SEC_W-1:0]                  sec7_reg;
    side_t                             side7_reg;

    always_comb
    begin
        prod_q   = (CH_W+CHANNEL_FRAC_BITS)'(side6_reg.sat)
                 * (CH_W+CHANNEL_FRAC_BITS)'(f6_reg);
        prod_tm  = (2*CH_W)'(side6_reg.sat) * (2*CH_W)'(ONE_C - CH_W'(f6_reg));
        mq7_next = prod_q[CHANNEL_FRAC_BITS +: CH_W];
        mt7_next = prod_tm[CHANNEL_FRAC_BITS +: CH_W];
    end

    // Stage 8: q and t, then channel selection by sector.
    logic [2*CH_W-1:0]  prod_qq;
    logic [2*CH_W-1:0]  prod_tt;
    logic [CH_W-1:0]    q_ch;
    logic [CH_W-1:0]    t_ch;
    logic [CH_W-1:0]    v_ch;
    logic [CH_W-1:0]    p_ch;
    logic [CH_W-1:0]    r_sel, g_sel, b_sel;
    logic [FIELD_W-1:0] red_reg,   red_next;
    logic [FIELD_W-1:0] green_reg, green_next;
    logic [FIELD_W-1:0] blue_reg,  blue_next;
    logic [FIELD_W-1:0] alpha_reg;

    always_comb
    begin
        v_ch    = side7_reg.val;
        p_ch    = side7_reg.p;
        prod_qq = (2*CH_W)'(v_ch) * (2*CH_W)'(ONE_C - mq7_reg);
        prod_tt = (2*CH_W)'(v_ch) * (2*CH_W)'(ONE_C - mt7_reg);
        q_ch    = prod_qq[CHANNEL_FRAC_BITS +: CH_W];
        t_ch    = prod_tt[CHANNEL_FRAC_BITS +: CH_W];
        unique case (sec7_reg)
            SEC_RED_YELLOW:
            begin
                r_sel = v_ch; g_sel = t_ch; b_sel = p_ch;
            end
            SEC_YELLOW_GREEN:
            begin
                r_sel = q_ch; g_sel = v_ch; b_sel = p_ch;
            end
            SEC_GREEN_CYAN:
            begin
                r_sel = p_ch; g_sel = v_ch; b_sel = t_ch;
            end
            SEC_CYAN_BLUE:
            begin
                r_sel = p_ch; g_sel = q_ch; b_sel = v_ch;
            end
            SEC_BLUE_MAGENTA:
            begin
                r_sel = t_ch; g_sel = p_ch; b_sel = v_ch;
            end
            default:
            begin
                r_sel = v_ch; g_sel = p_ch; b_sel = q_ch;
            end
        endcase
        // Zero saturation gives grey at the brightness level.
        if (side7_reg.grey)
        begin
            r_sel = v_ch; g_sel = v_ch; b_sel = v_ch;
        end
        red_next   = FIELD_W'(r_sel);
        green_next = FIELD_W'(g_sel);
        blue_next  = FIELD_W'(b_sel);
    end

    // Payload registers of all stages, held while the pipeline stalls.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u1_reg    <= u1_next;
            nt1_reg   <= nt1_next;
            side1_reg <= side1_next;

            h2_reg    <= h2_next;
            side2_reg <= side1_reg;

            h3_reg    <= h2_reg;
            ns3_reg   <= ns3_next;
            side3_reg <= side2_reg;

            rem4_reg  <= rem4_next;
            sec4_reg  <= sec4_next;
            side4_reg <= side3_reg;

            rem5_reg  <= rem4_reg;
            fe5_reg   <= fe5_next;
            sec5_reg  <= sec4_reg;
            side5_reg <= side4_reg;

            f6_reg    <= f6_next;
            sec6_reg  <= sec5_reg;
            side6_reg <= side5_reg;

            mq7_reg   <= mq7_next;
            mt7_reg   <= mt7_next;
            sec7_reg  <= sec6_reg;
            side7_reg <= side6_reg;

            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= side7_reg.alpha;
        end
    end

    assign m_axis_tdata = {alpha_reg, blue_reg, green_reg, red_reg};

endmodule
